/* rtl/pdfm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdfm_pkg
// Shared widths, register indexes, command codes and the job type passed
// from the capture front end to the arithmetic back end.
// ----------------------------------------------------------------------------
package pdfm_pkg;

  localparam int WIDTH_BITS = 24;
  localparam int PER_W      = WIDTH_BITS + 1;
  localparam int DUTY_W     = 10;
  localparam int CLK_W      = 27;
  localparam int REJ_W      = 8;
  localparam int PRE_W      = 16;
  localparam int SEL_W      = 2;
  localparam int NIB_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CLK_W;

  localparam int PERMILLE_FULL   = 1000;
  localparam int DEFAULT_CORE_HZ = 16000000;

  // duty numerator is high * 1000 + half period, frequency numerator is
  // capture clock + half period; the divider covers the wider of the two
  localparam int MUL_W   = WIDTH_BITS + DUTY_W;
  localparam int FNUM_W  = CLK_W + 1;
  localparam int NUM_W   = (MUL_W > FNUM_W) ? MUL_W : FNUM_W;
  localparam int DIV_STEPS = (NUM_W + 1) / 2;
  localparam int DNUM_W  = 2 * DIV_STEPS;
  localparam int DCNT_W  = $clog2(DIV_STEPS + 1);

  localparam logic [CFG_IDX_W-1:0] REG_CORE_CLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_SEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESCALER  = 2'd2;

  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_POLL    = 1'b1;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] high_width;
    logic [WIDTH_BITS-1:0] low_width;
    logic [REJ_W-1:0]      reject_count;
    logic [CLK_W-1:0]      capture_clock;
  } job_t;

endpackage

/* rtl/pwm_duty_frequency_meter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_duty_frequency_meter_top
// PWM duty cycle and frequency meter built from captured pulse widths.
// ----------------------------------------------------------------------------
// Capture words (tuser = 0) are handled in the cycle they are accepted and
// never produce output; a rejected capture bumps the 8-bit invalid counter.
// A poll word (tuser = 1) with both halves captured queues a measurement and
// clears the marks. In the back end each queued measurement goes through a
// pop, a multiply step, two passes of the shared radix-4 divider (each a
// start, 17 steps and a done; duty, then frequency) and the load of the
// output register; a zero period skips the divider. A two-entry queue lets
// the input keep taking words while the back end works, and input stalls
// only with both entries full or in reset. Configuration writes are
// expected only while the block is idle.
// ----------------------------------------------------------------------------
module pwm_duty_frequency_meter_top
  import pdfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [23:0] width_count, [24] pin_sample_first, [25] pin_sample_second,
  // [26] flag_pending, [31:27] zero
  input  logic [31:0]           s_tdata,
  // [0] command
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [23:0] high_width, [47:24] low_width, [72:48] period_count,
  // [82:73] duty_permille, [109:83] frequency_hz, [117:110] invalid_events,
  // [119:118] zero
  output logic [119:0]          m_tdata
);

  logic                  accept;
  logic                  push;
  job_t                  push_job;
  logic                  q_ready;
  logic                  pop;
  logic                  job_valid;
  job_t                  job;
  logic [WIDTH_BITS-1:0] high_width;
  logic [WIDTH_BITS-1:0] low_width;
  logic [PER_W-1:0]      period_count;
  logic [DUTY_W-1:0]     duty_permille;
  logic [CLK_W-1:0]      frequency_hz;
  logic [REJ_W-1:0]      invalid_events;

  assign s_tready = q_ready && !rst;
  assign accept   = s_tvalid && s_tready;

  pdfm_front u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .accept            (accept),
    .command           (s_tuser),
    .width_count       (s_tdata[23:0]),
    .pin_sample_first  (s_tdata[24]),
    .pin_sample_second (s_tdata[25]),
    .flag_pending      (s_tdata[26]),
    .push              (push),
    .push_job          (push_job)
  );

  pdfm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .wr_ready (q_ready),
    .pop      (pop),
    .rd_valid (job_valid),
    .pop_job  (job)
  );

  pdfm_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (job_valid),
    .job            (job),
    .pop            (pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .high_width     (high_width),
    .low_width      (low_width),
    .period_count   (period_count),
    .duty_permille  (duty_permille),
    .frequency_hz   (frequency_hz),
    .invalid_events (invalid_events)
  );

  assign m_tdata = {2'b00, invalid_events, frequency_hz, duty_permille,
                    period_count, low_width, high_width};

endmodule

/* rtl/pdfm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdfm_front
// Configuration registers and capture bookkeeping; a completed poll hands
// the measurement pair to the queue.
// ----------------------------------------------------------------------------
module pdfm_front
  import pdfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic                  command,
  input  logic [WIDTH_BITS-1:0] width_count,
  input  logic                  pin_sample_first,
  input  logic                  pin_sample_second,
  input  logic                  flag_pending,
  output logic                  push,
  output job_t                  push_job
);

  logic [CLK_W-1:0]      core_clock_hz;
  logic [SEL_W-1:0]      clock_source_select;
  logic [PRE_W-1:0]      prescaler_word;
  logic [WIDTH_BITS-1:0] high_width_reg;
  logic [WIDTH_BITS-1:0] low_width_reg;
  logic                  high_seen;
  logic                  low_seen;
  logic [REJ_W-1:0]      reject_count;
  logic [CLK_W-1:0]      core_eff;
  logic [NIB_W-1:0]      exponent;
  logic                  good_capture;

  always_ff @(posedge clk) begin
    if (rst) begin
      core_clock_hz       <= CLK_W'(DEFAULT_CORE_HZ);
      clock_source_select <= '0;
      prescaler_word      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CORE_CLOCK: core_clock_hz       <= cfg_data;
        REG_CLOCK_SEL:  clock_source_select <= cfg_data[SEL_W-1:0];
        REG_PRESCALER:  prescaler_word      <= cfg_data[PRE_W-1:0];
        default: ;
      endcase
    end
  end

  assign good_capture = !flag_pending && (pin_sample_first == pin_sample_second);
  assign push = accept && (command == CMD_POLL) && high_seen && low_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_width_reg <= '0;
      low_width_reg  <= '0;
      high_seen      <= 1'b0;
      low_seen       <= 1'b0;
      reject_count   <= '0;
    end else if (accept) begin
      if (command == CMD_CAPTURE) begin
        if (good_capture) begin
          // pin low now means a falling edge ended a high pulse
          if (!pin_sample_first) begin
            high_width_reg <= width_count;
            high_seen      <= 1'b1;
          end else begin
            low_width_reg <= width_count;
            low_seen      <= 1'b1;
          end
        end else begin
          reject_count <= reject_count + 1'b1;
        end
      end else if (push) begin
        high_seen <= 1'b0;
        low_seen  <= 1'b0;
      end
    end
  end

  assign core_eff = (core_clock_hz == '0) ? CLK_W'(DEFAULT_CORE_HZ) : core_clock_hz;
  assign exponent = prescaler_word[{clock_source_select, 2'b00} +: NIB_W];

  always_comb begin
    push_job.high_width    = high_width_reg;
    push_job.low_width     = low_width_reg;
    push_job.reject_count  = reject_count;
    push_job.capture_clock = core_eff >> exponent;
  end

endmodule

/* rtl/pdfm_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdfm_queue
// Two-entry job queue between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module pdfm_queue
  import pdfm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic wr_ready,
  input  logic pop,
  output logic rd_valid,
  output job_t pop_job
);

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign pop_job  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/pdfm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdfm_div
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module pdfm_div
  import pdfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DNUM_W-1:0] num,
  input  logic [PER_W-1:0]  den,
  output logic              done,
  output logic [DNUM_W-1:0] quot
);

  logic [PER_W-1:0]  rem;
  logic [PER_W-1:0]  divisor;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic [PER_W:0]    t1;
  logic [PER_W:0]    t2;
  logic [PER_W-1:0]  r1;
  logic [PER_W-1:0]  r2;
  logic              q1;
  logic              q2;

  always_comb begin
    t1 = {rem, quot[DNUM_W-1]};
    q1 = (t1 >= {1'b0, divisor});
    r1 = q1 ? PER_W'(t1 - {1'b0, divisor}) : t1[PER_W-1:0];
    t2 = {r1, quot[DNUM_W-2]};
    q2 = (t2 >= {1'b0, divisor});
    r2 = q2 ? PER_W'(t2 - {1'b0, divisor}) : t2[PER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      quot    <= num;
      divisor <= den;
    end else if (busy) begin
      rem  <= r2;
      quot <= {quot[DNUM_W-3:0], q1, q2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/pdfm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdfm_back
// Takes a job from the queue, adds up the period, forms duty and frequency on
// the shared divider and leaves the result in the output register.
// ----------------------------------------------------------------------------
module pdfm_back
  import pdfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  input  job_t                  job,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [WIDTH_BITS-1:0] high_width,
  output logic [WIDTH_BITS-1:0] low_width,
  output logic [PER_W-1:0]      period_count,
  output logic [DUTY_W-1:0]     duty_permille,
  output logic [CLK_W-1:0]      frequency_hz,
  output logic [REJ_W-1:0]      invalid_events
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL    = 7'b0000010,
    S_DUTY   = 7'b0000100,
    S_WAIT_D = 7'b0001000,
    S_FREQ   = 7'b0010000,
    S_WAIT_F = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t            state;
  job_t              cur;
  logic [PER_W-1:0]  period;
  logic [DNUM_W-1:0] duty_num;
  logic [DNUM_W-1:0] freq_num;
  logic [DUTY_W-1:0] duty;
  logic [CLK_W-1:0]  freq;
  logic              div_start;
  logic [DNUM_W-1:0] div_num;
  logic              div_done;
  logic [DNUM_W-1:0] div_quot;
  logic [MUL_W-1:0]  product;
  logic              out_free;

  assign pop       = (state == S_IDLE) && job_valid;
  assign out_free  = !out_valid || out_ready;
  assign div_start = (state == S_DUTY) || (state == S_FREQ);
  assign div_num   = (state == S_DUTY) ? duty_num : freq_num;
  assign product   = MUL_W'(cur.high_width) * MUL_W'(PERMILLE_FULL);

  pdfm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (period),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:   if (job_valid) state <= S_MUL;
        S_MUL:    state <= (period == '0) ? S_FIN : S_DUTY;
        S_DUTY:   state <= S_WAIT_D;
        S_WAIT_D: if (div_done) state <= S_FREQ;
        S_FREQ:   state <= S_WAIT_F;
        S_WAIT_F: if (div_done) state <= S_FIN;
        S_FIN:    if (out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur    <= job;
      period <= PER_W'(job.high_width) + PER_W'(job.low_width);
    end
    if (state == S_MUL) begin
      duty_num <= DNUM_W'(product) + DNUM_W'(period >> 1);
      freq_num <= DNUM_W'(cur.capture_clock) + DNUM_W'(period >> 1);
      duty     <= '0;
      freq     <= '0;
    end
    if ((state == S_WAIT_D) && div_done) begin
      duty <= (div_quot > DNUM_W'(PERMILLE_FULL)) ? DUTY_W'(PERMILLE_FULL)
                                                  : div_quot[DUTY_W-1:0];
    end
    if ((state == S_WAIT_F) && div_done) begin
      freq <= div_quot[CLK_W-1:0];
    end
    if ((state == S_FIN) && out_free) begin
      high_width     <= cur.high_width;
      low_width      <= cur.low_width;
      period_count   <= period;
      duty_permille  <= duty;
      frequency_hz   <= freq;
      invalid_events <= cur.reject_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* dv/pwm_duty_frequency_meter_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_duty_frequency_meter_top_test
// Self-checking bench for the PWM duty/frequency meter. A short table of
// directed words (corner widths, rejected captures, polls with and without
// both halves) is followed by randomized capture/poll sequences under several
// clock and prescaler settings. A behavioral tracker of the meter predicts
// every measurement word not typed into the table, and the output stream
// is checked field by field under random backpressure, including one long
// stall of the output side.
module pwm_duty_frequency_meter_top_test;
  import pdfm_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] high_w;
    logic [WIDTH_BITS-1:0] low_w;
    logic [PER_W-1:0]      period;
    logic [DUTY_W-1:0]     duty;
    logic [CLK_W-1:0]      freq;
    logic [REJ_W-1:0]      invalid;
  } meas_t;

  typedef struct packed {
    logic                  cmd;
    logic [WIDTH_BITS-1:0] width;
    logic                  pin_a;
    logic                  pin_b;
    logic                  pend;
    logic                  typed;
    meas_t                 exp;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [119:0]          m_tdata;

  // tracker state of the meter
  logic [WIDTH_BITS-1:0] hi_w = '0;
  logic [WIDTH_BITS-1:0] lo_w = '0;
  logic                  hi_seen = 1'b0;
  logic                  lo_seen = 1'b0;
  logic [REJ_W-1:0]      rej_cnt = '0;
  logic [CLK_W-1:0]      core_hz = CLK_W'(DEFAULT_CORE_HZ);
  logic [SEL_W-1:0]      clk_sel = '0;
  logic [PRE_W-1:0]      pre_word = '0;

  meas_t meas_q[$];
  int    fail_cnt = 0;
  bit    src_idle = 1'b0;
  logic  sink_idle_on = 1'b0;
  logic  hold_req = 1'b0;
  logic  hold_taken = 1'b0;
  int    stall_left = 0;

  pwm_duty_frequency_meter_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5 clk = ~clk;

  // Directed words. Expected values typed in only where obvious.
  dir_row_t dir_table [23] = '{
    '{CMD_POLL,    24'd0,        1'b0, 1'b0, 1'b0, 1'b0, '0},  // poll after reset
    '{CMD_CAPTURE, 24'd0,        1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_CAPTURE, 24'd0,        1'b1, 1'b1, 1'b0, 1'b0, '0},
    '{CMD_POLL,    24'd0,        1'b0, 1'b0, 1'b0, 1'b1, '0},  // zero period
    '{CMD_POLL,    24'd0,        1'b0, 1'b0, 1'b0, 1'b0, '0},  // marks cleared
    '{CMD_CAPTURE, 24'hFFFFFF,   1'b0, 1'b0, 1'b1, 1'b0, '0},  // flag pending
    '{CMD_CAPTURE, 24'h123456,   1'b0, 1'b1, 1'b0, 1'b0, '0},  // pins disagree
    '{CMD_CAPTURE, 24'h654321,   1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_CAPTURE, 24'd1,        1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_CAPTURE, 24'd1,        1'b1, 1'b1, 1'b0, 1'b0, '0},
    '{CMD_POLL,    24'd0,        1'b0, 1'b0, 1'b0, 1'b1,
      '{24'd1, 24'd1, 25'd2, 10'd500, 27'd8000000, 8'd3}},
    '{CMD_CAPTURE, 24'hFFFFFF,   1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_POLL,    24'd0,        1'b0, 1'b0, 1'b0, 1'b0, '0},  // high half only
    '{CMD_CAPTURE, 24'd0,        1'b1, 1'b1, 1'b0, 1'b0, '0},
    '{CMD_POLL,    24'd0,        1'b0, 1'b0, 1'b0, 1'b0, '0},  // full duty
    '{CMD_CAPTURE, 24'd0,        1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_CAPTURE, 24'hFFFFFF,   1'b1, 1'b1, 1'b0, 1'b0, '0},
    '{CMD_POLL,    24'd0,        1'b0, 1'b0, 1'b0, 1'b0, '0},  // zero duty
    '{CMD_CAPTURE, 24'hFFFFFF,   1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_CAPTURE, 24'hFFFFFF,   1'b1, 1'b1, 1'b0, 1'b0, '0},
    '{CMD_POLL,    24'd0,        1'b0, 1'b0, 1'b0, 1'b0, '0},  // longest period
    '{CMD_CAPTURE, 24'hFFFFFF,   1'b1, 1'b1, 1'b1, 1'b0, '0},
    '{CMD_POLL,    24'd0,        1'b0, 1'b0, 1'b0, 1'b0, '0}
  };

  function automatic logic [31:0] pack_capture(input logic [WIDTH_BITS-1:0] w,
                                               input logic pa, input logic pb,
                                               input logic pend);
    return {5'b0, pend, pb, pa, w};
  endfunction

  function automatic logic [WIDTH_BITS-1:0] rand_width();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return WIDTH_BITS'($urandom_range(1, 255));
      default: return WIDTH_BITS'($urandom);
    endcase
  endfunction

  // Updates the tracked state for one word; returns 1 with the measurement
  // when a poll finds both halves captured.
  function automatic bit track_word(input logic cmd, input logic [31:0] data,
                                    output meas_t res);
    logic [WIDTH_BITS-1:0] w;
    logic                  pa, pb, pend;
    logic [NIB_W-1:0]      shift;
    longint unsigned       per, half, duty, core, capclk, freq;
    w    = data[WIDTH_BITS-1:0];
    pa   = data[24];
    pb   = data[25];
    pend = data[26];
    res  = '0;
    if (cmd == CMD_CAPTURE) begin
      if (!pend && pa == pb) begin
        // pin low now means the falling edge closed a high pulse
        if (!pa) begin
          hi_w = w;
          hi_seen = 1'b1;
        end else begin
          lo_w = w;
          lo_seen = 1'b1;
        end
      end else begin
        rej_cnt = rej_cnt + 1'b1;
      end
      return 1'b0;
    end
    if (!(hi_seen && lo_seen)) return 1'b0;
    per  = 64'(hi_w) + 64'(lo_w);
    half = per >> 1;
    duty = 0;
    freq = 0;
    if (per != 0) begin
      core   = (core_hz == 0) ? 64'(DEFAULT_CORE_HZ) : 64'(core_hz);
      shift  = pre_word[clk_sel*NIB_W +: NIB_W];
      capclk = core >> shift;
      duty   = (64'(hi_w) * PERMILLE_FULL + half) / per;
      if (duty > PERMILLE_FULL) duty = PERMILLE_FULL;
      freq   = (capclk + half) / per;
    end
    res.high_w  = hi_w;
    res.low_w   = lo_w;
    res.period  = PER_W'(per);
    res.duty    = DUTY_W'(duty);
    res.freq    = CLK_W'(freq);
    res.invalid = rej_cnt;
    hi_seen = 1'b0;
    lo_seen = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_word(input logic cmd, input logic [31:0] data,
                           input bit typed = 1'b0, input meas_t typed_res = '0);
    meas_t res;
    bit    produced;
    if (src_idle && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    produced = track_word(cmd, data, res);
    if (typed) meas_q.push_back(typed_res);
    else if (produced) meas_q.push_back(res);
  endtask

  task automatic send_reject();
    logic pend = 1'($urandom_range(0, 1));
    logic pa   = 1'($urandom_range(0, 1));
    logic pb   = pend ? 1'($urandom_range(0, 1)) : !pa;
    send_word(CMD_CAPTURE, pack_capture(rand_width(), pa, pb, pend));
  endtask

  task automatic run_sequence();
    int   kind      = $urandom_range(0, 9);
    logic low_first = 1'($urandom_range(0, 1));
    logic lvl;
    if (kind <= 6) begin
      for (int h = 0; h < 2; h++) begin
        lvl = low_first ^ h[0];
        repeat ($urandom_range(0, 2)) send_reject();
        send_word(CMD_CAPTURE, pack_capture(rand_width(), lvl, lvl, 1'b0));
        if ($urandom_range(0, 4) == 0)  // later capture overwrites the half
          send_word(CMD_CAPTURE, pack_capture(rand_width(), lvl, lvl, 1'b0));
      end
      send_word(CMD_POLL, {5'b0, 27'($urandom)});
      if (kind == 6) send_word(CMD_POLL, {5'b0, 27'($urandom)});
    end else if (kind == 7) begin
      lvl = 1'($urandom_range(0, 1));
      send_word(CMD_CAPTURE, pack_capture(rand_width(), lvl, lvl, 1'b0));
      send_word(CMD_POLL, {5'b0, 27'($urandom)});
    end else if (kind == 8) begin
      send_word(1'($urandom_range(0, 1)), {5'b0, 27'($urandom)});
    end else begin
      repeat ($urandom_range(1, 4)) send_reject();
    end
  endtask

  // Wait for all measurements, then let the back end settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (meas_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CLK_W-1:0] core, input logic [SEL_W-1:0] sel,
                               input logic [PRE_W-1:0] pre, input bit poke_unused);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    int                    n;
    idx[0] = REG_CORE_CLOCK;
    val[0] = core;
    idx[1] = REG_CLOCK_SEL;
    val[1] = {(CFG_DATA_W-SEL_W)'($urandom), sel};
    idx[2] = REG_PRESCALER;
    val[2] = {(CFG_DATA_W-PRE_W)'($urandom), pre};
    idx[3] = REG_UNUSED;
    val[3] = CFG_DATA_W'($urandom);
    n = poke_unused ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    core_hz  = core;
    clk_sel  = sel;
    pre_word = pre;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // output side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      stall_left <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 11);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    meas_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (meas_q.size() == 0) begin
        $error("measurement word with nothing expected: %h", m_tdata);
        fail_cnt++;
      end else begin
        want = meas_q.pop_front();
        check_field("high_width",     want.high_w,  m_tdata[23:0]);
        check_field("low_width",      want.low_w,   m_tdata[47:24]);
        check_field("period_count",   want.period,  m_tdata[72:48]);
        check_field("duty_permille",  want.duty,    m_tdata[82:73]);
        check_field("frequency_hz",   want.freq,    m_tdata[109:83]);
        check_field("invalid_events", want.invalid, m_tdata[117:110]);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    src_idle = 1'b1;
    sink_idle_on <= 1'b1;

    for (int i = 0; i < 23; i++)
      send_word(dir_table[i].cmd,
                pack_capture(dir_table[i].width, dir_table[i].pin_a,
                             dir_table[i].pin_b, dir_table[i].pend),
                dir_table[i].typed, dir_table[i].exp);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_setting(27'd0, 2'd0, 16'h0000, 1'b0);         // zero -> default clock
        1: apply_setting(27'd100000000, 2'd3, 16'hF000, 1'b0);
        2: apply_setting(27'd1, 2'd1, 16'hFFFF, 1'b1);         // capture clock of zero
        3: apply_setting(CLK_W'($urandom_range(0, 100000000)),
                         SEL_W'($urandom_range(0, 3)), PRE_W'($urandom), 1'b1);
        4: apply_setting(27'd100000000, 2'd2, 16'h0000, 1'b0);
        default: apply_setting(CLK_W'($urandom_range(0, 100000000)),
                               SEL_W'($urandom_range(0, 3)), PRE_W'($urandom), 1'b0);
      endcase
      if (p == 0) hold_req <= 1'b1;
      if (p == 3) repeat (210) send_reject();  // push the reject counter past a wrap
      if (p == 5) begin
        src_idle = 1'b0;
        sink_idle_on <= 1'b0;
      end
      repeat (9) run_sequence();
      drain();
    end

    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
